[rtl/bit_field_store_defines.svh]
`ifndef BIT_FIELD_STORE_DEFINES_SVH
`define BIT_FIELD_STORE_DEFINES_SVH

// Check a consequent in the same cycle as its antecedent.
`define BFS_ASSERT_NOW(label, clk_s, rst_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequent in the cycle after its antecedent.
`define BFS_ASSERT_NEXT(label, clk_s, rst_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/bfs_pkg.sv]
package bfs_pkg;

  localparam int WORD_W      = 32;
  localparam int OFS_W       = 5;
  localparam int IDX_W       = 11;
  localparam int FW_W        = 6;
  localparam int CFG_W       = 7;
  localparam int SLOT_W      = IDX_W - OFS_W;
  localparam int STORE_WORDS = 1 << SLOT_W;
  localparam int BANK_AW     = SLOT_W - 1;
  localparam int BANK_DEPTH  = STORE_WORDS / 2;
  localparam int CNT_W       = SLOT_W + 1;

  localparam logic [CFG_W-1:0]  CFG_RESET = CFG_W'(64);
  localparam logic [CNT_W-1:0]  CNT_ONE   = CNT_W'(1);
  localparam logic [FW_W-1:0]   FW_MAX    = FW_W'(WORD_W);
  localparam logic [WORD_W-1:0] WORD_ONE  = WORD_W'(1);

  localparam logic [2:0] CMD_CLEAR_ALL   = 3'd0;
  localparam logic [2:0] CMD_SET_ALL     = 3'd1;
  localparam logic [2:0] CMD_SET_BIT     = 3'd2;
  localparam logic [2:0] CMD_CLR_BIT     = 3'd3;
  localparam logic [2:0] CMD_TGL_BIT     = 3'd4;
  localparam logic [2:0] CMD_READ_FIELD  = 3'd5;
  localparam logic [2:0] CMD_WRITE_FIELD = 3'd6;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_WIDTH = 2'd2;

  typedef struct packed {
    logic [2:0]        cmd;
    logic [IDX_W-1:0]  bit_index;
    logic [FW_W-1:0]   field_width;
    logic [WORD_W-1:0] write_value;
  } bfs_in_t;

  typedef struct packed {
    logic [WORD_W-1:0] read_data;
    logic [1:0]        status;
  } bfs_out_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_FILL,
    OP_SET,
    OP_CLR,
    OP_TGL,
    OP_READ,
    OP_WRITE
  } bfs_op_t;

  typedef struct packed {
    bfs_op_t           op;
    logic              fill;
    logic [SLOT_W-1:0] slot;
    logic              hi_ok;
    logic [OFS_W-1:0]  ofs;
    logic [WORD_W-1:0] fmask;
    logic [WORD_W-1:0] value;
    logic [CNT_W-1:0]  count;
    logic [1:0]        status;
  } bfs_req_t;

  typedef struct packed {
    logic [BANK_AW-1:0] raddr;
    logic               we;
    logic [BANK_AW-1:0] waddr;
    logic [WORD_W-1:0]  wdata;
  } bfs_ram_cmd_t;

  typedef enum logic {
    B_IDLE,
    B_EXEC
  } bfs_bstate_t;

  function automatic logic [CNT_W-1:0] active_count(input logic [CFG_W-1:0] c);
    if (c > CFG_W'(STORE_WORDS)) begin
      return CNT_W'(STORE_WORDS);
    end
    return CNT_W'(c);
  endfunction

  function automatic logic word_active(input int unsigned i, input logic [CNT_W-1:0] n);
    return CNT_W'(i) < n;
  endfunction

endpackage

[rtl/bfs_bank.sv]
module bfs_bank (
  input  logic                               clk,
  input  bfs_pkg::bfs_ram_cmd_t              cmd,
  output logic [bfs_pkg::WORD_W-1:0]         rdata
);

  logic [bfs_pkg::WORD_W-1:0] mem [bfs_pkg::BANK_DEPTH];

  always_ff @(posedge clk) begin
    if (cmd.we) begin
      mem[cmd.waddr] <= cmd.wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[cmd.raddr];
  end

endmodule

[rtl/bfs_front.sv]
module bfs_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_push,
  output logic                          in_full,
  input  bfs_pkg::bfs_in_t              in_data,
  input  logic                          cfg_we,
  input  logic [bfs_pkg::CFG_W-1:0]     cfg_wdata,
  output bfs_pkg::bfs_req_t             req,
  output logic                          req_valid,
  input  logic                          req_take
);

  logic [bfs_pkg::CFG_W-1:0]  cfg_r;
  bfs_pkg::bfs_req_t          q_r [2];
  logic                       wptr_r;
  logic                       rptr_r;
  logic [1:0]                 cnt_r;

  logic [bfs_pkg::SLOT_W-1:0] slot;
  logic [bfs_pkg::CNT_W-1:0]  n;
  logic                       in_range;
  logic                       hi_ok;
  logic                       width_ok;
  logic [bfs_pkg::WORD_W-1:0] fmask;
  logic                       push;
  bfs_pkg::bfs_req_t          cls;

  always_comb begin
    slot     = in_data.bit_index[bfs_pkg::IDX_W-1:bfs_pkg::OFS_W];
    n        = bfs_pkg::active_count(cfg_r);
    in_range = {1'b0, slot} < n;
    hi_ok    = ({1'b0, slot} + bfs_pkg::CNT_ONE) < n;
    width_ok = (in_data.field_width != '0) && (in_data.field_width <= bfs_pkg::FW_MAX);
    if (in_data.field_width[bfs_pkg::OFS_W]) begin
      fmask = '1;
    end else begin
      fmask = (bfs_pkg::WORD_ONE << in_data.field_width[bfs_pkg::OFS_W-1:0])
              - bfs_pkg::WORD_ONE;
    end

    cls        = '0;
    cls.op     = bfs_pkg::OP_NONE;
    cls.slot   = slot;
    cls.hi_ok  = hi_ok;
    cls.ofs    = in_data.bit_index[bfs_pkg::OFS_W-1:0];
    cls.fmask  = fmask;
    cls.value  = in_data.write_value & fmask;
    cls.count  = n;
    cls.status = bfs_pkg::ST_OK;

    unique case (in_data.cmd)
      bfs_pkg::CMD_CLEAR_ALL: begin
        cls.op = bfs_pkg::OP_FILL;
      end
      bfs_pkg::CMD_SET_ALL: begin
        cls.op   = bfs_pkg::OP_FILL;
        cls.fill = 1'b1;
      end
      bfs_pkg::CMD_SET_BIT: begin
        if (in_range) cls.op = bfs_pkg::OP_SET;
        else          cls.status = bfs_pkg::ST_RANGE;
      end
      bfs_pkg::CMD_CLR_BIT: begin
        if (in_range) cls.op = bfs_pkg::OP_CLR;
        else          cls.status = bfs_pkg::ST_RANGE;
      end
      bfs_pkg::CMD_TGL_BIT: begin
        if (in_range) cls.op = bfs_pkg::OP_TGL;
        else          cls.status = bfs_pkg::ST_RANGE;
      end
      bfs_pkg::CMD_READ_FIELD: begin
        if (!width_ok)     cls.status = bfs_pkg::ST_WIDTH;
        else if (!in_range) cls.status = bfs_pkg::ST_RANGE;
        else               cls.op = bfs_pkg::OP_READ;
      end
      bfs_pkg::CMD_WRITE_FIELD: begin
        if (!width_ok)     cls.status = bfs_pkg::ST_WIDTH;
        else if (!in_range) cls.status = bfs_pkg::ST_RANGE;
        else               cls.op = bfs_pkg::OP_WRITE;
      end
      default: begin
      end
    endcase
  end

  assign in_full   = (cnt_r == 2'd2);
  assign push      = in_push && !in_full;
  assign req_valid = (cnt_r != 2'd0);
  assign req       = q_r[rptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r  <= bfs_pkg::CFG_RESET;
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      if (cfg_we) begin
        cfg_r <= cfg_wdata;
      end
      if (push) begin
        wptr_r <= !wptr_r;
      end
      if (req_take) begin
        rptr_r <= !rptr_r;
      end
      if (push && !req_take) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (!push && req_take) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wptr_r] <= cls;
    end
  end

endmodule

[rtl/bfs_back.sv]
`include "bit_field_store_defines.svh"

module bfs_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  bfs_pkg::bfs_req_t             req,
  input  logic                          req_valid,
  output logic                          req_take,
  output bfs_pkg::bfs_ram_cmd_t         even_cmd,
  output bfs_pkg::bfs_ram_cmd_t         odd_cmd,
  input  logic [bfs_pkg::WORD_W-1:0]    even_rdata,
  input  logic [bfs_pkg::WORD_W-1:0]    odd_rdata,
  output logic                          out_empty,
  input  logic                          out_pop,
  output bfs_pkg::bfs_out_t             out_data
);

  bfs_pkg::bfs_bstate_t             state_r;
  bfs_pkg::bfs_bstate_t             state_nxt;
  bfs_pkg::bfs_req_t                cur_r;
  logic [bfs_pkg::STORE_WORDS-1:0]  vld_r;
  logic [bfs_pkg::STORE_WORDS-1:0]  fil_r;
  bfs_pkg::bfs_out_t                oq_r [2];
  logic                             owp_r;
  logic                             orp_r;
  logic [1:0]                       ocnt_r;

  logic                             exec;
  logic                             opop;
  logic [bfs_pkg::SLOT_W-1:0]       hi_slot;
  logic [bfs_pkg::BANK_AW-1:0]      head_base;
  logic [bfs_pkg::BANK_AW-1:0]      cur_base;
  logic [bfs_pkg::WORD_W-1:0]       lo_w;
  logic [bfs_pkg::WORD_W-1:0]       hi_w;
  logic [2*bfs_pkg::WORD_W-1:0]     win;
  logic [2*bfs_pkg::WORD_W-1:0]     pm;
  logic [2*bfs_pkg::WORD_W-1:0]     pv;
  logic [2*bfs_pkg::WORD_W-1:0]     shifted;
  logic [bfs_pkg::WORD_W-1:0]       bit_m;
  logic [bfs_pkg::WORD_W-1:0]       new_lo;
  logic [bfs_pkg::WORD_W-1:0]       new_hi;
  logic                             wr_lo;
  logic                             wr_hi;
  bfs_pkg::bfs_out_t                res;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bfs_pkg::B_IDLE: begin
        if (req_valid && (ocnt_r != 2'd2)) state_nxt = bfs_pkg::B_EXEC;
      end
      bfs_pkg::B_EXEC: begin
        state_nxt = bfs_pkg::B_IDLE;
      end
    endcase
  end

  always_comb begin
    req_take = (state_r == bfs_pkg::B_IDLE) && req_valid && (ocnt_r != 2'd2);
    exec     = (state_r == bfs_pkg::B_EXEC);
  end

  always_comb begin
    hi_slot = cur_r.slot + 1'b1;
    lo_w    = cur_r.slot[0] ? odd_rdata : even_rdata;
    if (!vld_r[cur_r.slot]) lo_w = {bfs_pkg::WORD_W{fil_r[cur_r.slot]}};
    hi_w    = cur_r.slot[0] ? even_rdata : odd_rdata;
    if (!vld_r[hi_slot]) hi_w = {bfs_pkg::WORD_W{fil_r[hi_slot]}};
    if (!cur_r.hi_ok) hi_w = '0;

    win     = {hi_w, lo_w};
    bit_m   = bfs_pkg::WORD_ONE << cur_r.ofs;
    pm      = {{bfs_pkg::WORD_W{1'b0}}, cur_r.fmask} << cur_r.ofs;
    pv      = {{bfs_pkg::WORD_W{1'b0}}, cur_r.value} << cur_r.ofs;
    shifted = win >> cur_r.ofs;

    new_lo = lo_w;
    new_hi = hi_w;
    wr_lo  = 1'b0;
    wr_hi  = 1'b0;
    if (exec) begin
      unique case (cur_r.op)
        bfs_pkg::OP_SET: begin
          new_lo = lo_w | bit_m;
          wr_lo  = 1'b1;
        end
        bfs_pkg::OP_CLR: begin
          new_lo = lo_w & ~bit_m;
          wr_lo  = 1'b1;
        end
        bfs_pkg::OP_TGL: begin
          new_lo = lo_w ^ bit_m;
          wr_lo  = 1'b1;
        end
        bfs_pkg::OP_WRITE: begin
          {new_hi, new_lo} = (win & ~pm) | pv;
          wr_lo = 1'b1;
          wr_hi = cur_r.hi_ok;
        end
        default: begin
        end
      endcase
    end

    res.status    = cur_r.status;
    res.read_data = '0;
    if (cur_r.op == bfs_pkg::OP_READ) begin
      res.read_data = shifted[bfs_pkg::WORD_W-1:0] & cur_r.fmask;
    end
  end

  // Words slot and slot+1 always sit in opposite banks.
  always_comb begin
    head_base      = req.slot[bfs_pkg::SLOT_W-1:1];
    cur_base       = cur_r.slot[bfs_pkg::SLOT_W-1:1];
    even_cmd.raddr = req.slot[0] ? head_base + 1'b1 : head_base;
    odd_cmd.raddr  = head_base;
    if (!cur_r.slot[0]) begin
      even_cmd.we    = wr_lo;
      even_cmd.waddr = cur_base;
      even_cmd.wdata = new_lo;
      odd_cmd.we     = wr_hi;
      odd_cmd.waddr  = cur_base;
      odd_cmd.wdata  = new_hi;
    end else begin
      odd_cmd.we     = wr_lo;
      odd_cmd.waddr  = cur_base;
      odd_cmd.wdata  = new_lo;
      even_cmd.we    = wr_hi;
      even_cmd.waddr = cur_base + 1'b1;
      even_cmd.wdata = new_hi;
    end
  end

  assign out_empty = (ocnt_r == 2'd0);
  assign opop      = out_pop && !out_empty;
  assign out_data  = oq_r[orp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bfs_pkg::B_IDLE;
      vld_r   <= '0;
      fil_r   <= '0;
      owp_r   <= 1'b0;
      orp_r   <= 1'b0;
      ocnt_r  <= 2'd0;
    end else begin
      state_r <= state_nxt;
      if (exec && (cur_r.op == bfs_pkg::OP_FILL)) begin
        for (int unsigned i = 0; i < bfs_pkg::STORE_WORDS; i++) begin
          if (bfs_pkg::word_active(i, cur_r.count)) begin
            vld_r[i] <= 1'b0;
            fil_r[i] <= cur_r.fill;
          end
        end
      end else begin
        if (wr_lo) vld_r[cur_r.slot] <= 1'b1;
        if (wr_hi) vld_r[hi_slot] <= 1'b1;
      end
      if (exec) begin
        owp_r <= !owp_r;
      end
      if (opop) begin
        orp_r <= !orp_r;
      end
      if (exec && !opop) begin
        ocnt_r <= ocnt_r + 2'd1;
      end else if (!exec && opop) begin
        ocnt_r <= ocnt_r - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_take) begin
      cur_r <= req;
    end
    if (exec) begin
      oq_r[owp_r] <= res;
    end
  end

  `BFS_ASSERT_NOW(a_take_room, clk, rst_n, req_take, ocnt_r != 2'd2, "request taken with result queue full")
  `BFS_ASSERT_NOW(a_flag_no_write, clk, rst_n, exec && (cur_r.status != bfs_pkg::ST_OK), !even_cmd.we && !odd_cmd.we, "flagged request wrote the store")
  `BFS_ASSERT_NOW(a_pair_write, clk, rst_n, even_cmd.we && odd_cmd.we, (cur_r.op == bfs_pkg::OP_WRITE) && cur_r.hi_ok, "two words written outside a straddling field write")
  `BFS_ASSERT_NEXT(a_exec_push, clk, rst_n, exec && !opop, ocnt_r == $past(ocnt_r) + 2'd1, "result of executed request not queued")

endmodule

[rtl/bit_field_store.sv]
// A taken request sits in cur_r and runs in the EXEC state, which queues its result
// for the out_ ports. A new request is taken only when idle and the result queue has
// room. The word pair is read from the even and odd banks as a request is taken, and
// is modified and written back in EXEC; clear-all and set-all use per-word fill flags.
// Reset (synchronous, rst_n low): store reads as all zero at once, words_in_use = 64,
// both queues empty; no clearing pass.
module bit_field_store (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_push,
  output logic                          in_full,
  input  bfs_pkg::bfs_in_t              in_data,
  output logic                          out_empty,
  input  logic                          out_pop,
  output bfs_pkg::bfs_out_t             out_data,
  input  logic                          cfg_we,
  input  logic [bfs_pkg::CFG_W-1:0]     cfg_wdata
);

  bfs_pkg::bfs_req_t            req;
  logic                         req_valid;
  logic                         req_take;
  bfs_pkg::bfs_ram_cmd_t        even_cmd;
  bfs_pkg::bfs_ram_cmd_t        odd_cmd;
  logic [bfs_pkg::WORD_W-1:0]   even_rdata;
  logic [bfs_pkg::WORD_W-1:0]   odd_rdata;

  bfs_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req       (req),
    .req_valid (req_valid),
    .req_take  (req_take)
  );

  bfs_bank u_even (
    .clk   (clk),
    .cmd   (even_cmd),
    .rdata (even_rdata)
  );

  bfs_bank u_odd (
    .clk   (clk),
    .cmd   (odd_cmd),
    .rdata (odd_rdata)
  );

  bfs_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .req        (req),
    .req_valid  (req_valid),
    .req_take   (req_take),
    .even_cmd   (even_cmd),
    .odd_cmd    (odd_cmd),
    .even_rdata (even_rdata),
    .odd_rdata  (odd_rdata),
    .out_empty  (out_empty),
    .out_pop    (out_pop),
    .out_data   (out_data)
  );

endmodule

[verif/tb_top.sv]
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import bfs_pkg::*;

  localparam logic [2:0] CMD_UNUSED = 3'd7;
  localparam int unsigned QUIET_LIMIT = 3000;

  logic              clk;
  logic              rst_n;
  logic              in_push;
  logic              in_full;
  bfs_in_t           in_data;
  logic              out_empty;
  logic              out_pop = 1'b0;
  bfs_out_t          out_data;
  logic              cfg_we;
  logic [CFG_W-1:0]  cfg_wdata;

  logic [WORD_W-1:0] word_image [STORE_WORDS];
  logic [CFG_W-1:0]  words_cfg;
  bfs_out_t          due_replies [$];
  bfs_out_t          oldest_reply;

  bit                no_idle = 1'b0;
  int unsigned       rx_hold = 0;
  int unsigned       quiet_cycles = 0;
  int unsigned       mismatches = 0;
  int unsigned       requests_sent = 0;
  int unsigned       replies_checked = 0;
  int unsigned       sizes_used = 0;

  bit_field_store dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_data   (in_data),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  function automatic bfs_out_t apply_command(input bfs_in_t req);
    logic [CNT_W-1:0]  n;
    logic [SLOT_W-1:0] slot;
    logic [OFS_W-1:0]  ofs;
    logic [63:0]       fmask;
    logic [63:0]       win;
    int unsigned       hi;
    bfs_out_t          res;
    n = (words_cfg > CFG_W'(STORE_WORDS)) ? CNT_W'(STORE_WORDS) : CNT_W'(words_cfg);
    slot = req.bit_index[IDX_W-1:OFS_W];
    ofs = req.bit_index[OFS_W-1:0];
    hi = slot + 1;
    res = '0;
    res.status = ST_OK;
    case (req.cmd)
      CMD_CLEAR_ALL, CMD_SET_ALL: begin
        for (int i = 0; i < n; i++) begin
          word_image[i] = (req.cmd == CMD_SET_ALL) ? '1 : '0;
        end
      end
      CMD_SET_BIT, CMD_CLR_BIT, CMD_TGL_BIT: begin
        if (slot >= n) begin
          res.status = ST_RANGE;
        end else if (req.cmd == CMD_SET_BIT) begin
          word_image[slot][ofs] = 1'b1;
        end else if (req.cmd == CMD_CLR_BIT) begin
          word_image[slot][ofs] = 1'b0;
        end else begin
          word_image[slot][ofs] = ~word_image[slot][ofs];
        end
      end
      CMD_READ_FIELD, CMD_WRITE_FIELD: begin
        if (req.field_width == '0 || req.field_width > FW_MAX) begin
          res.status = ST_WIDTH;
        end else if (slot >= n) begin
          res.status = ST_RANGE;
        end else begin
          fmask = (64'd1 << req.field_width) - 64'd1;
          win = {32'd0, word_image[slot]};
          if (hi < n) begin
            win[63:32] = word_image[hi];
          end
          if (req.cmd == CMD_READ_FIELD) begin
            res.read_data = WORD_W'((win >> ofs) & fmask);
          end else begin
            win = (win & ~(fmask << ofs)) | ((64'(req.write_value) & fmask) << ofs);
            word_image[slot] = win[31:0];
            if (hi < n) begin
              word_image[hi] = win[63:32];
            end
          end
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic bfs_in_t mk_req(input logic [2:0] c, input int unsigned idx,
                                     input int unsigned fw, input logic [31:0] v);
    bfs_in_t r;
    r.cmd = c;
    r.bit_index = IDX_W'(idx);
    r.field_width = FW_W'(fw);
    r.write_value = v;
    return r;
  endfunction

  function automatic int unsigned idle_gap();
    int unsigned r;
    if (no_idle) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  function automatic bfs_in_t random_request();
    int unsigned live;
    int unsigned top;
    int unsigned r;
    bfs_in_t     req;
    live = (words_cfg > CFG_W'(STORE_WORDS)) ? STORE_WORDS : words_cfg;
    top = (live == 0) ? 0 : live * 32 - 1;
    r = $urandom_range(0, 99);
    if (r < 4) begin
      req.cmd = CMD_CLEAR_ALL;
    end else if (r < 8) begin
      req.cmd = CMD_SET_ALL;
    end else if (r < 20) begin
      req.cmd = CMD_SET_BIT;
    end else if (r < 30) begin
      req.cmd = CMD_CLR_BIT;
    end else if (r < 42) begin
      req.cmd = CMD_TGL_BIT;
    end else if (r < 70) begin
      req.cmd = CMD_READ_FIELD;
    end else if (r < 97) begin
      req.cmd = CMD_WRITE_FIELD;
    end else begin
      req.cmd = CMD_UNUSED;
    end
    r = $urandom_range(0, 99);
    if (live == 0 || r < 10) begin
      req.bit_index = IDX_W'($urandom_range(0, 2047));
    end else if (r < 30) begin
      req.bit_index = IDX_W'(top - $urandom_range(0, (top < 40) ? top : 40));
    end else begin
      req.bit_index = IDX_W'($urandom_range(0, top));
    end
    r = $urandom_range(0, 99);
    if (r < 8) begin
      req.field_width = ($urandom_range(0, 1) == 0) ? '0 : FW_W'($urandom_range(33, 63));
    end else if (r < 22) begin
      req.field_width = FW_MAX;
    end else begin
      req.field_width = FW_W'($urandom_range(1, 32));
    end
    req.write_value = $urandom;
    return req;
  endfunction

  task automatic issue_request(input bfs_in_t req);
    int unsigned gap;
    in_push <= 1'b1;
    in_data <= req;
    @(posedge clk);
    while (in_full) begin
      @(posedge clk);
    end
    due_replies.push_back(apply_command(req));
    requests_sent++;
    gap = idle_gap();
    if (gap != 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic settle();
    in_push <= 1'b0;
    @(posedge clk);
    while (due_replies.size() != 0) begin
      @(posedge clk);
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic configure(input logic [CFG_W-1:0] v);
    settle();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    words_cfg = v;
    sizes_used++;
  endtask

  task automatic test_directed_ops();
    issue_request(mk_req(CMD_READ_FIELD, 0, 32, '0));
    issue_request(mk_req(CMD_SET_ALL, 0, 0, '0));
    issue_request(mk_req(CMD_READ_FIELD, 2016, 32, '0));
    issue_request(mk_req(CMD_READ_FIELD, 2040, 32, '0));
    issue_request(mk_req(CMD_CLEAR_ALL, 2047, 63, '1));
    issue_request(mk_req(CMD_SET_BIT, 0, 0, '0));
    issue_request(mk_req(CMD_SET_BIT, 2047, 0, '0));
    issue_request(mk_req(CMD_TGL_BIT, 2047, 0, '0));
    issue_request(mk_req(CMD_TGL_BIT, 37, 0, '0));
    issue_request(mk_req(CMD_CLR_BIT, 0, 0, '0));
    issue_request(mk_req(CMD_WRITE_FIELD, 30, 4, '1));
    issue_request(mk_req(CMD_READ_FIELD, 28, 8, '0));
    issue_request(mk_req(CMD_WRITE_FIELD, 100, 1, 32'hFFFF_FFFE));
    issue_request(mk_req(CMD_WRITE_FIELD, 2047, 32, '1));
    issue_request(mk_req(CMD_READ_FIELD, 2016, 32, '0));
    issue_request(mk_req(CMD_READ_FIELD, 0, 0, '0));
    issue_request(mk_req(CMD_WRITE_FIELD, 0, 33, '1));
    issue_request(mk_req(CMD_READ_FIELD, 0, 63, '0));
    issue_request(mk_req(CMD_UNUSED, 2047, 63, '1));
    issue_request(mk_req(CMD_WRITE_FIELD, 64, 32, 32'hA5C3_0F96));
    issue_request(mk_req(CMD_READ_FIELD, 64, 32, '0));
  endtask

  task automatic test_store_limits();
    configure(7'd1);
    issue_request(mk_req(CMD_SET_BIT, 32, 0, '0));
    issue_request(mk_req(CMD_WRITE_FIELD, 16, 32, '1));
    issue_request(mk_req(CMD_READ_FIELD, 0, 32, '0));
    issue_request(mk_req(CMD_CLEAR_ALL, 0, 0, '0));
    configure(7'd0);
    issue_request(mk_req(CMD_SET_ALL, 0, 0, '0));
    issue_request(mk_req(CMD_READ_FIELD, 0, 0, '0));
    issue_request(mk_req(CMD_TGL_BIT, 0, 0, '0));
    configure(7'd127);
    issue_request(mk_req(CMD_READ_FIELD, 32, 32, '0));
  endtask

  task automatic test_random_traffic();
    logic [CFG_W-1:0] sizes [9];
    int unsigned      count;
    sizes = '{7'd1, 7'd64, 7'd2, 7'd0, 7'd33, 7'd127, 7'd63, 7'd64, 7'd0};
    sizes[8] = CFG_W'($urandom_range(1, 127));
    for (int p = 0; p < 9; p++) begin
      configure(sizes[p]);
      count = (sizes[p] == '0) ? 40 : 200;
      for (int k = 0; k < count; k++) begin
        if (k % 50 == 0) begin
          no_idle = ($urandom_range(0, 3) == 0);
        end
        if (k == count / 2) begin
          settle();
        end
        issue_request(random_request());
      end
    end
    no_idle = 1'b0;
  endtask

  // hold off the receiver at random, with short and long stalls
  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else if (rx_hold != 0) begin
      out_pop <= 1'b0;
      rx_hold <= rx_hold - 1;
    end else begin
      out_pop <= 1'b1;
      if ($urandom_range(0, 3) == 0) begin
        rx_hold <= idle_gap();
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty) begin
      if (due_replies.size() == 0) begin
        $display("%0t: unexpected reply, expected none, got read_data %h status %0d",
                 $time, out_data.read_data, out_data.status);
        mismatches++;
      end else begin
        oldest_reply = due_replies.pop_front();
        replies_checked++;
        if (out_data.read_data !== oldest_reply.read_data) begin
          $display("%0t: read_data mismatch, expected %h, got %h",
                   $time, oldest_reply.read_data, out_data.read_data);
          mismatches++;
        end
        if (out_data.status !== oldest_reply.status) begin
          $display("%0t: status mismatch, expected %0d, got %0d",
                   $time, oldest_reply.status, out_data.status);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_push && !in_full) || (out_pop && !out_empty)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_push = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    words_cfg = CFG_RESET;
    foreach (word_image[i]) begin
      word_image[i] = '0;
    end
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    test_directed_ops();
    test_store_limits();
    test_random_traffic();

    settle();
    repeat (6) @(posedge clk);
    if (due_replies.size() != 0) begin
      $display("%0t: %0d expected replies never arrived", $time, due_replies.size());
      mismatches++;
    end
    $display("sent %0d requests, checked %0d replies, across %0d store size settings",
             requests_sent, replies_checked, sizes_used);
    $display("exercised all commands, bad widths, out-of-range indices and straddling fields");
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
